@@ design/i2cmra_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types, phase codes, command and status codes, and bus timing
// constants for the I2C register access core.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

  // Command codes carried in the op field.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_PROBE = 2'd3;

  // Completion status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_START_FAIL = 2'd1;
  localparam logic [1:0] ST_ADDR_NACK  = 2'd2;

  // Reset value of the acknowledge timeout register.
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

  // Tick counts of the bus phases.
  localparam logic [15:0] DUR_ONE  = 16'd1;
  localparam logic [15:0] DUR_BIT  = 16'd2;
  localparam logic [15:0] DUR_STOP = 16'd4;
  localparam logic [15:0] DUR_LONG = 16'd5;
  localparam logic [15:0] DUR_NONE = 16'd0;

  // Last bit position of a byte.
  localparam logic [3:0] LAST_BIT = 4'd7;

  // Bus sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_A   = 5'd1,
    PH_RS_A   = 5'd2,
    PH_ST_B   = 5'd3,
    PH_ST_C   = 5'd4,
    PH_ST_D   = 5'd5,
    PH_TX_LO  = 5'd6,
    PH_TX_HI  = 5'd7,
    PH_TX_LO2 = 5'd8,
    PH_AK_A   = 5'd9,
    PH_AK_P   = 5'd10,
    PH_WAIT   = 5'd11,
    PH_RX_LO  = 5'd12,
    PH_RX_HI  = 5'd13,
    PH_RA_LO  = 5'd14,
    PH_RA_HI  = 5'd15,
    PH_SP_A   = 5'd16,
    PH_SP_B   = 5'd17,
    PH_SP_C   = 5'd18
  } phase_t;

  // Kind of the byte being shifted out.
  typedef enum logic [1:0] {
    KIND_ADDR_W = 2'd0,
    KIND_REG    = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_ADDR_R = 2'd3
  } kind_t;

  // One input beat: a microsecond tick with an optional command.
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] sub_addr;
    logic [7:0] length;
    logic [7:0] wr_data;
    logic       data_valid;
    logic       sda_in;
  } cmd_t;

  // One result beat: line drive and transaction events for the tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       need_data;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       done_res;
    logic [1:0] status;
  } rsp_t;

endpackage

@@ design/i2c_master_register_access_core.sv @@
// ----------------------------------------------------------------------------
// I2C master register access core
// Bit-level I2C master driven by one tick beat per microsecond. It runs
// probe, register write and register read transactions with open-drain
// line control and reports line levels and events for every tick.
// ----------------------------------------------------------------------------
// A result is registered in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle while results are taken; the sequencer
//   state and the result register update together in the accepting cycle.
// Reset (rst, synchronous): sequencer idle, counters and held command cleared,
//   acknowledge timeout set to 1000 ticks, no result pending.
module i2c_master_register_access_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  i2cmra_pkg::cmd_t   cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output i2cmra_pkg::rsp_t   rsp,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);
  import i2cmra_pkg::*;

  // Sequencer state.
  phase_t      phase, phase_next;
  kind_t       kind, kind_next;
  logic [15:0] tick_count, tick_next;
  logic [7:0]  shift_byte, shift_next;
  logic [3:0]  bit_index, bit_next;
  logic [7:0]  bytes_left, bytes_next;
  logic [6:0]  held_addr, addr_next;
  logic [7:0]  held_reg, reg_next;
  logic [1:0]  held_op, op_next;
  logic [1:0]  result_code, code_next;
  logic [15:0] ack_timeout;

  // Per-tick events and helpers.
  logic        accept;
  logic        ack_go;
  logic        acked;
  logic [15:0] tick_dec;
  logic        ev_done, ev_rd_valid, ev_rd_last;
  logic [1:0]  ev_status;
  logic [7:0]  ev_rd_byte;
  rsp_t        rsp_next;

  // The result register frees up as soon as its beat is taken.
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign tick_dec  = tick_count - 16'd1;

  // Next-state logic for one tick.
  always_comb begin
    phase_next  = phase;
    kind_next   = kind;
    tick_next   = tick_count;
    shift_next  = shift_byte;
    bit_next    = bit_index;
    bytes_next  = bytes_left;
    addr_next   = held_addr;
    reg_next    = held_reg;
    op_next     = held_op;
    code_next   = result_code;
    ack_go      = 1'b0;
    acked       = 1'b0;
    ev_done     = 1'b0;
    ev_status   = ST_OK;
    ev_rd_valid = 1'b0;
    ev_rd_last  = 1'b0;
    ev_rd_byte  = 8'd0;

    case (phase)
      PH_IDLE: begin
        if (cmd.op != OP_TICK) begin
          op_next    = cmd.op;
          addr_next  = cmd.dev_addr;
          reg_next   = cmd.sub_addr;
          bytes_next = cmd.length;
          kind_next  = KIND_ADDR_W;
          code_next  = ST_OK;
          phase_next = PH_ST_A;
          tick_next  = DUR_ONE;
        end
      end
      PH_AK_P: begin
        if (!cmd.sda_in) begin
          ack_go = 1'b1;
          acked  = 1'b1;
        end else if (tick_count >= ack_timeout) begin
          ack_go = 1'b1;
        end else begin
          tick_next = tick_count + 16'd1;
        end
      end
      PH_WAIT: begin
        if (cmd.data_valid) begin
          bytes_next = bytes_left - 8'd1;
          shift_next = cmd.wr_data;
          kind_next  = KIND_DATA;
          bit_next   = 4'd0;
          phase_next = PH_TX_LO;
          tick_next  = DUR_BIT;
        end
      end
      default: begin
        tick_next = tick_dec;
        if (tick_dec == 16'd0) begin
          case (phase)
            PH_ST_A, PH_RS_A: begin
              phase_next = PH_ST_B;
              tick_next  = DUR_LONG;
            end
            PH_ST_B: begin
              if (!cmd.sda_in) begin
                ev_done    = 1'b1;
                ev_status  = ST_START_FAIL;
                phase_next = PH_IDLE;
                tick_next  = DUR_NONE;
              end else begin
                phase_next = PH_ST_C;
                tick_next  = DUR_LONG;
              end
            end
            PH_ST_C: begin
              if (cmd.sda_in) begin
                ev_done    = 1'b1;
                ev_status  = ST_START_FAIL;
                phase_next = PH_IDLE;
                tick_next  = DUR_NONE;
              end else begin
                phase_next = PH_ST_D;
                tick_next  = DUR_BIT;
              end
            end
            PH_ST_D: begin
              shift_next = {held_addr, kind == KIND_ADDR_R};
              bit_next   = 4'd0;
              phase_next = PH_TX_LO;
              tick_next  = DUR_BIT;
            end
            PH_TX_LO: begin
              phase_next = PH_TX_HI;
              tick_next  = DUR_BIT;
            end
            PH_TX_HI: begin
              phase_next = PH_TX_LO2;
              tick_next  = DUR_BIT;
            end
            PH_TX_LO2: begin
              if (bit_index >= LAST_BIT) begin
                phase_next = PH_AK_A;
                tick_next  = DUR_ONE;
              end else begin
                bit_next   = bit_index + 4'd1;
                shift_next = {shift_byte[6:0], 1'b0};
                phase_next = PH_TX_LO;
                tick_next  = DUR_BIT;
              end
            end
            PH_AK_A: begin
              phase_next = PH_AK_P;
              tick_next  = DUR_NONE;
            end
            PH_RX_LO: begin
              shift_next = {shift_byte[6:0], cmd.sda_in};
              phase_next = PH_RX_HI;
              tick_next  = DUR_ONE;
            end
            PH_RX_HI: begin
              if (bit_index >= LAST_BIT) begin
                ev_rd_valid = 1'b1;
                ev_rd_byte  = shift_byte;
                ev_rd_last  = (bytes_left == 8'd1);
                phase_next  = PH_RA_LO;
                tick_next   = DUR_BIT;
              end else begin
                bit_next   = bit_index + 4'd1;
                phase_next = PH_RX_LO;
                tick_next  = DUR_BIT;
              end
            end
            PH_RA_LO: begin
              phase_next = PH_RA_HI;
              tick_next  = DUR_BIT;
            end
            PH_RA_HI: begin
              bytes_next = bytes_left - 8'd1;
              if (bytes_left != 8'd1) begin
                shift_next = 8'd0;
                bit_next   = 4'd0;
                phase_next = PH_RX_LO;
                tick_next  = DUR_BIT;
              end else begin
                code_next  = ST_OK;
                phase_next = PH_SP_A;
                tick_next  = DUR_STOP;
              end
            end
            PH_SP_A: begin
              phase_next = PH_SP_B;
              tick_next  = DUR_LONG;
            end
            PH_SP_B: begin
              phase_next = PH_SP_C;
              tick_next  = DUR_STOP;
            end
            PH_SP_C: begin
              ev_done    = 1'b1;
              ev_status  = result_code;
              phase_next = PH_IDLE;
              tick_next  = DUR_NONE;
            end
            default: begin
              phase_next = PH_IDLE;
              tick_next  = DUR_NONE;
            end
          endcase
        end
      end
    endcase

    // Acknowledge outcome: only the address bytes judge it.
    if (ack_go) begin
      case (kind)
        KIND_ADDR_W: begin
          if (!acked) begin
            code_next  = ST_ADDR_NACK;
            phase_next = PH_SP_A;
            tick_next  = DUR_STOP;
          end else if (held_op == OP_PROBE) begin
            code_next  = ST_OK;
            phase_next = PH_SP_A;
            tick_next  = DUR_STOP;
          end else begin
            shift_next = held_reg;
            kind_next  = KIND_REG;
            bit_next   = 4'd0;
            phase_next = PH_TX_LO;
            tick_next  = DUR_BIT;
          end
        end
        KIND_REG, KIND_DATA: begin
          if (kind == KIND_REG && held_op == OP_READ) begin
            kind_next  = KIND_ADDR_R;
            phase_next = PH_RS_A;
            tick_next  = DUR_ONE;
          end else if (bytes_left != 8'd0) begin
            phase_next = PH_WAIT;
            tick_next  = DUR_NONE;
          end else begin
            code_next  = ST_OK;
            phase_next = PH_SP_A;
            tick_next  = DUR_STOP;
          end
        end
        default: begin
          if (!acked) begin
            code_next  = ST_ADDR_NACK;
            phase_next = PH_SP_A;
            tick_next  = DUR_STOP;
          end else if (bytes_left != 8'd0) begin
            shift_next = 8'd0;
            bit_next   = 4'd0;
            phase_next = PH_RX_LO;
            tick_next  = DUR_BIT;
          end else begin
            code_next  = ST_OK;
            phase_next = PH_SP_A;
            tick_next  = DUR_STOP;
          end
        end
      endcase
    end
  end

  // Line drive and result fields, taken from the state after this tick.
  always_comb begin
    rsp_next             = '0;
    rsp_next.scl_out     = 1'b1;
    rsp_next.sda_release = 1'b1;
    case (phase_next)
      PH_RS_A, PH_AK_A, PH_WAIT, PH_RX_LO: begin
        rsp_next.scl_out = 1'b0;
      end
      PH_ST_C, PH_SP_B: begin
        rsp_next.sda_release = 1'b0;
      end
      PH_ST_D, PH_SP_A: begin
        rsp_next.scl_out     = 1'b0;
        rsp_next.sda_release = 1'b0;
      end
      PH_TX_LO, PH_TX_LO2: begin
        rsp_next.scl_out     = 1'b0;
        rsp_next.sda_release = shift_next[7];
      end
      PH_TX_HI: begin
        rsp_next.sda_release = shift_next[7];
      end
      PH_RA_LO: begin
        rsp_next.scl_out     = 1'b0;
        rsp_next.sda_release = (bytes_next == 8'd1);
      end
      PH_RA_HI: begin
        rsp_next.sda_release = (bytes_next == 8'd1);
      end
      default: begin
      end
    endcase
    rsp_next.busy_res  = (phase_next != PH_IDLE);
    rsp_next.need_data = (phase_next == PH_WAIT);
    rsp_next.rd_byte   = ev_rd_byte;
    rsp_next.rd_valid  = ev_rd_valid;
    rsp_next.rd_last   = ev_rd_last;
    rsp_next.done_res  = ev_done;
    rsp_next.status    = ev_status;
  end

  // Sequencer state registers advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      kind        <= KIND_ADDR_W;
      tick_count  <= 16'd0;
      shift_byte  <= 8'd0;
      bit_index   <= 4'd0;
      bytes_left  <= 8'd0;
      held_addr   <= 7'd0;
      held_reg    <= 8'd0;
      held_op     <= OP_TICK;
      result_code <= ST_OK;
    end else if (accept) begin
      phase       <= phase_next;
      kind        <= kind_next;
      tick_count  <= tick_next;
      shift_byte  <= shift_next;
      bit_index   <= bit_next;
      bytes_left  <= bytes_next;
      held_addr   <= addr_next;
      held_reg    <= reg_next;
      held_op     <= op_next;
      result_code <= code_next;
    end
  end

  // Acknowledge timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      ack_timeout <= cfg_data;
    end
  end

  // Result register with its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // A finished transaction leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |-> !rsp.busy_res)
    else $error("done reported while still busy");

  // An error status only comes with the end of a transaction.
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.done_res)
    else $error("nonzero status without done");

  // While waiting for write data the clock is held low.
  a_wait_scl_low: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.need_data |-> !rsp.scl_out && rsp.busy_res)
    else $error("waiting for data with SCL released");

  // Read byte fields are quiet outside a completed read byte.
  a_rd_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.rd_valid |-> (rsp.rd_byte == 8'd0) && !rsp.rd_last)
    else $error("read fields active without rd_valid");

  // The idle sequencer keeps its tick counter cleared.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == 16'd0)
    else $error("tick counter nonzero while idle");
`endif

endmodule

@@ tb/tb_i2c_master_register_access_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the I2C master register access core
// Sends one tick beat at a time, with a simple slave model that chooses the
// sampled SDA level. A tick predictor computes the expected result beat for
// every accepted tick, and each result beat is compared field by field.
// Probe, write and read transfers run under several acknowledge timeouts,
// with random stalls on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_core;
  import i2cmra_pkg::*;

  // How the slave model disturbs the start condition.
  localparam int NO_FAIL   = 0;
  localparam int FAIL_LOW  = 1;
  localparam int FAIL_HIGH = 2;

  localparam int HOLD_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 30;

  // Predicts the result beat of every tick and checks the ones that arrive.
  class i2c_tick_scoreboard;
    logic [15:0] ack_limit;
    phase_t      ph;
    logic [15:0] ticks;
    logic [7:0]  shreg;
    logic [3:0]  bitn;
    logic [7:0]  left;
    logic [6:0]  addr;
    logic [7:0]  regb;
    logic [1:0]  opc;
    kind_t       kind;
    logic [1:0]  code;
    rsp_t        nx;
    rsp_t        want_q[$];
    int          errors;
    int          n_ticks;
    int          n_checked;
    int          n_ok;
    int          n_start_fail;
    int          n_nack;
    int          n_rd_bytes;

    function new();
      ack_limit = ACK_TIMEOUT_RESET;
      ph = PH_IDLE;
      ticks = '0;
      shreg = '0;
      bitn = '0;
      left = '0;
      addr = '0;
      regb = '0;
      opc = OP_TICK;
      kind = KIND_ADDR_W;
      code = ST_OK;
      nx = '0;
      nx.scl_out = 1'b1;
      nx.sda_release = 1'b1;
      errors = 0;
      n_ticks = 0;
      n_checked = 0;
      n_ok = 0;
      n_start_fail = 0;
      n_nack = 0;
      n_rd_bytes = 0;
    endfunction

    function void go(phase_t p, logic [15:0] dur);
      ph = p;
      ticks = dur;
    endfunction

    function void send_byte(logic [7:0] v, kind_t k);
      shreg = v;
      kind = k;
      bitn = '0;
      go(PH_TX_LO, DUR_BIT);
    endfunction

    function void send_stop(logic [1:0] c);
      code = c;
      go(PH_SP_A, DUR_STOP);
    endfunction

    function void recv_byte();
      shreg = '0;
      bitn = '0;
      go(PH_RX_LO, DUR_BIT);
    endfunction

    function void end_transfer(logic [1:0] c);
      nx.done_res = 1'b1;
      nx.status = c;
      case (c)
        ST_OK: n_ok++;
        ST_START_FAIL: n_start_fail++;
        default: n_nack++;
      endcase
      go(PH_IDLE, DUR_NONE);
    endfunction

    function void next_write();
      if (left != 0) go(PH_WAIT, DUR_NONE);
      else send_stop(ST_OK);
    endfunction

    // Only the address bytes judge the acknowledge.
    function void ack_seen(bit acked);
      case (kind)
        KIND_ADDR_W: begin
          if (!acked) send_stop(ST_ADDR_NACK);
          else if (opc == OP_PROBE) send_stop(ST_OK);
          else send_byte(regb, KIND_REG);
        end
        KIND_REG: begin
          if (opc == OP_READ) begin
            kind = KIND_ADDR_R;
            go(PH_RS_A, DUR_ONE);
          end else begin
            next_write();
          end
        end
        KIND_DATA: next_write();
        default: begin
          if (!acked) send_stop(ST_ADDR_NACK);
          else if (left != 0) recv_byte();
          else send_stop(ST_OK);
        end
      endcase
    endfunction

    // A timed phase has run out; move on, sampling SDA where the bus needs it.
    function void phase_over(logic sda);
      case (ph)
        PH_ST_A, PH_RS_A: go(PH_ST_B, DUR_LONG);
        PH_ST_B: begin
          if (!sda) end_transfer(ST_START_FAIL);
          else go(PH_ST_C, DUR_LONG);
        end
        PH_ST_C: begin
          if (sda) end_transfer(ST_START_FAIL);
          else go(PH_ST_D, DUR_BIT);
        end
        PH_ST_D: send_byte({addr, kind == KIND_ADDR_R}, kind);
        PH_TX_LO: go(PH_TX_HI, DUR_BIT);
        PH_TX_HI: go(PH_TX_LO2, DUR_BIT);
        PH_TX_LO2: begin
          if (bitn >= LAST_BIT) begin
            go(PH_AK_A, DUR_ONE);
          end else begin
            bitn++;
            shreg = shreg << 1;
            go(PH_TX_LO, DUR_BIT);
          end
        end
        PH_AK_A: go(PH_AK_P, DUR_NONE);
        PH_RX_LO: begin
          shreg = {shreg[6:0], sda};
          go(PH_RX_HI, DUR_ONE);
        end
        PH_RX_HI: begin
          if (bitn >= LAST_BIT) begin
            nx.rd_valid = 1'b1;
            nx.rd_byte = shreg;
            nx.rd_last = (left == 8'd1);
            n_rd_bytes++;
            go(PH_RA_LO, DUR_BIT);
          end else begin
            bitn++;
            go(PH_RX_LO, DUR_BIT);
          end
        end
        PH_RA_LO: go(PH_RA_HI, DUR_BIT);
        PH_RA_HI: begin
          left--;
          if (left != 0) recv_byte();
          else send_stop(ST_OK);
        end
        PH_SP_A: go(PH_SP_B, DUR_LONG);
        PH_SP_B: go(PH_SP_C, DUR_STOP);
        PH_SP_C: end_transfer(code);
        default: go(PH_IDLE, DUR_NONE);
      endcase
    endfunction

    // Advances the bus by one accepted tick and queues the result it causes.
    function void note_tick(cmd_t c);
      nx = '0;
      n_ticks++;
      case (ph)
        PH_IDLE: begin
          if (c.op != OP_TICK) begin
            opc = c.op;
            addr = c.dev_addr;
            regb = c.sub_addr;
            left = c.length;
            kind = KIND_ADDR_W;
            code = ST_OK;
            go(PH_ST_A, DUR_ONE);
          end
        end
        PH_AK_P: begin
          if (!c.sda_in) ack_seen(1'b1);
          else if (ticks >= ack_limit) ack_seen(1'b0);
          else ticks++;
        end
        PH_WAIT: begin
          if (c.data_valid) begin
            left--;
            send_byte(c.wr_data, KIND_DATA);
          end
        end
        default: begin
          ticks--;
          if (ticks == 0) phase_over(c.sda_in);
        end
      endcase

      // Line drive held until the next tick.
      nx.scl_out = 1'b1;
      nx.sda_release = 1'b1;
      case (ph)
        PH_RS_A, PH_AK_A, PH_WAIT, PH_RX_LO: nx.scl_out = 1'b0;
        PH_ST_C, PH_SP_B: nx.sda_release = 1'b0;
        PH_ST_D, PH_SP_A: begin
          nx.scl_out = 1'b0;
          nx.sda_release = 1'b0;
        end
        PH_TX_LO, PH_TX_LO2: begin
          nx.scl_out = 1'b0;
          nx.sda_release = shreg[7];
        end
        PH_TX_HI: nx.sda_release = shreg[7];
        PH_RA_LO: begin
          nx.scl_out = 1'b0;
          nx.sda_release = (left == 8'd1);
        end
        PH_RA_HI: nx.sda_release = (left == 8'd1);
        default: ;
      endcase
      nx.busy_res = (ph != PH_IDLE);
      nx.need_data = (ph == PH_WAIT);
      want_q.push_back(nx);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("beat %0d %s: got %0h, want %0h", n_checked, what, got, want);
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (want_q.size() == 0) begin
        report("result beat with nothing pending", 32'(got), 32'd0);
        return;
      end
      want = want_q.pop_front();
      if (got.scl_out !== want.scl_out)
        report("scl_out", 32'(got.scl_out), 32'(want.scl_out));
      if (got.sda_release !== want.sda_release)
        report("sda_release", 32'(got.sda_release), 32'(want.sda_release));
      if (got.busy_res !== want.busy_res)
        report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
      if (got.need_data !== want.need_data)
        report("need_data", 32'(got.need_data), 32'(want.need_data));
      if (got.rd_byte !== want.rd_byte)
        report("rd_byte", 32'(got.rd_byte), 32'(want.rd_byte));
      if (got.rd_valid !== want.rd_valid)
        report("rd_valid", 32'(got.rd_valid), 32'(want.rd_valid));
      if (got.rd_last !== want.rd_last)
        report("rd_last", 32'(got.rd_last), 32'(want.rd_last));
      if (got.done_res !== want.done_res)
        report("done_res", 32'(got.done_res), 32'(want.done_res));
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      n_checked++;
    endtask

    task flush_leftovers();
      while (want_q.size() != 0) begin
        report("result beat never arrived", 32'd0, 32'(want_q.pop_front()));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_t        cmd = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  i2c_tick_scoreboard sb = new();

  // Slave model plan for the transfer in flight.
  int   plan_fail = NO_FAIL;
  bit   plan_addr_ack = 1'b1;
  bit   ack_now = 1'b1;
  int   ack_hold = 0;
  int   poll_n = 0;

  // Receiver stall control.
  logic rx_stall_en = 1'b0;
  int   hold_requests = 0;
  int   hold_seen = 0;
  int   rx_stall_left = 0;

  int   cycle_count = 0;
  int   n_settings = 1;

  i2c_master_register_access_core dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check every accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      rx_stall_left = HOLD_CYCLES;
    end else if (rx_stall_left == 0 && rx_stall_en && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 8);
    end
    if (rx_stall_left != 0) begin
      rsp_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one tick beat and waits until it is accepted.
  task automatic offer(input cmd_t c);
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    sb.note_tick(c);
  endtask

  task automatic pause_sender(input int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stops sending until every predicted result beat has been checked.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (sb.want_q.size() != 0);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.ack_limit = v;
    n_settings++;
  endtask

  // SDA level the slave side shows in the next tick.
  task automatic slave_level(output logic lvl);
    logic drive;
    drive = sb.nx.sda_release;
    case (sb.ph)
      PH_ST_B: lvl = (plan_fail == FAIL_LOW) ? 1'b0 : drive;
      PH_ST_C: lvl = (plan_fail == FAIL_HIGH) ? 1'b1 : drive;
      PH_AK_A: begin
        if (sb.kind == KIND_ADDR_W) ack_now = plan_addr_ack;
        else ack_now = (sb.ack_limit > 16'd64) || ($urandom_range(0, 6) != 0);
        ack_hold = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 12))
                                               : int'($urandom_range(0, 2));
        poll_n = 0;
        lvl = drive;
      end
      PH_AK_P: begin
        lvl = !(ack_now && poll_n >= ack_hold);
        poll_n++;
      end
      PH_RX_LO, PH_RX_HI: lvl = 1'($urandom_range(0, 1));
      default: lvl = ($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : drive;
    endcase
  endtask

  // Builds the next tick; a new transfer starts only when allowed and idle.
  task automatic make_tick(input bit may_start, output cmd_t c);
    int r;
    logic lvl;
    c.dev_addr = 7'($urandom);
    c.sub_addr = 8'($urandom);
    c.length = 8'($urandom);
    c.wr_data = 8'($urandom);
    c.data_valid = ($urandom_range(0, 2) != 0);
    c.op = OP_TICK;
    if (sb.ph != PH_IDLE) begin
      // Commands during a transfer must be ignored.
      if ($urandom_range(0, 4) == 0) c.op = 2'($urandom_range(0, 3));
    end else if (may_start && $urandom_range(0, 3) == 0) begin
      r = $urandom_range(0, 9);
      c.op = (r < 3) ? OP_PROBE : (r < 6) ? OP_WRITE : OP_READ;
      c.length = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
      plan_fail = ($urandom_range(0, 5) == 0) ? int'($urandom_range(FAIL_LOW, FAIL_HIGH))
                                              : NO_FAIL;
      plan_addr_ack = (sb.ack_limit > 16'd64) || ($urandom_range(0, 6) != 0);
    end
    slave_level(lvl);
    c.sda_in = lvl;
  endtask

  // Runs one command with a fixed slave plan until the bus is idle again.
  task automatic run_transfer(input logic [1:0] op, input logic [6:0] sa,
                              input logic [7:0] ra, input logic [7:0] len,
                              input int fail_mode, input bit addr_ok);
    cmd_t c;
    c.op = op;
    c.dev_addr = sa;
    c.sub_addr = ra;
    c.length = len;
    c.wr_data = 8'($urandom);
    c.data_valid = 1'b1;
    c.sda_in = 1'b1;
    plan_fail = fail_mode;
    plan_addr_ack = addr_ok;
    offer(c);
    while (sb.ph != PH_IDLE) begin
      make_tick(1'b0, c);
      offer(c);
    end
  endtask

  // Random ticks with quiet stretches; the last transfer is allowed to finish.
  task automatic run_phase(input int beats, input bit gaps, input bit rx_en,
                           input bit do_hold, input bit do_drain);
    cmd_t c;
    int i;
    i = 0;
    while (i < beats || sb.ph != PH_IDLE) begin
      rx_stall_en <= rx_en && ((i / 64) % 3 != 1);
      if (do_hold && i == 40) hold_requests <= hold_requests + 1;
      if (do_drain && i == 120) wait_drained();
      make_tick(i < beats, c);
      offer(c);
      if (gaps && ((i / 64) % 3 != 2) && $urandom_range(0, 9) == 0)
        pause_sender($urandom_range(1, 8));
      i++;
    end
  endtask

  // Main sequence.
  initial begin
    cmd_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes on idle ticks, then start failures.
    c = '1;
    c.op = OP_TICK;
    c.sda_in = 1'b0;
    offer(c);
    c = '0;
    offer(c);
    run_transfer(OP_PROBE, 7'h7F, 8'hFF, 8'hFF, FAIL_LOW, 1'b1);
    run_transfer(OP_WRITE, 7'h00, 8'h00, 8'hFF, FAIL_HIGH, 1'b1);
    run_transfer(OP_READ, 7'h2A, 8'h80, 8'h80, FAIL_LOW, 1'b1);

    // Reset timeout value.
    run_phase(100, 1'b1, 1'b1, 1'b0, 1'b0);

    // Short timeout: failed address, zero-length write and read first.
    write_timeout(16'd3);
    run_transfer(OP_PROBE, 7'h55, 8'h12, 8'h00, NO_FAIL, 1'b0);
    run_transfer(OP_WRITE, 7'h33, 8'hA5, 8'h00, NO_FAIL, 1'b1);
    run_transfer(OP_READ, 7'h4C, 8'h5A, 8'h00, NO_FAIL, 1'b1);
    run_phase(100, 1'b1, 1'b1, 1'b0, 1'b0);

    // Zero timeout, with a pause until all results are in.
    write_timeout(16'd0);
    run_phase(130, 1'b1, 1'b1, 1'b0, 1'b1);

    // Largest timeout, with the long receiver hold-off.
    write_timeout(16'hFFFF);
    run_phase(100, 1'b1, 1'b1, 1'b1, 1'b0);

    write_timeout(16'd1);
    run_phase(80, 1'b1, 1'b1, 1'b0, 1'b0);

    // Final stretch without any idling.
    write_timeout(16'($urandom_range(2, 12)));
    run_phase(140, 1'b0, 1'b0, 1'b0, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk);
    sb.flush_leftovers();

    $display("Covered %0d tick beats under %0d timeout settings, with stalls on both sides.",
             sb.n_ticks, n_settings);
    $display("Transfers: %0d completed, %0d start failures, %0d address NACKs, %0d bytes read.",
             sb.n_ok, sb.n_start_fail, sb.n_nack, sb.n_rd_bytes);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/i2cmra_pkg.sv
design/i2c_master_register_access_core.sv
tb/tb_i2c_master_register_access_core.sv
